@@ rtl/tap_tempo_metronome_defines.svh @@
// Assertion macros shared by the metronome RTL.
// They expect the clock to be named clk and the reset to be named arst_n.
`ifndef TAP_TEMPO_METRONOME_DEFINES_SVH
`define TAP_TEMPO_METRONOME_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ttm_pkg.sv @@
`default_nettype none

package ttm_pkg;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_START_STOP = 2'd1,
		OP_ENTER_TAP  = 2'd2,
		OP_TAP        = 2'd3
	} op_t;

	// Operating modes.
	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_TAP  = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BEATS_PER_BAR = 2'd0,
		REG_SOUND_ENABLE  = 2'd1,
		REG_PRESET_BPM    = 2'd2
	} reg_index_t;

	// Field widths.
	localparam int BPM_W      = 8;
	localparam int BAR_W      = 4;
	localparam int SEC_W      = 6;
	localparam int SUB_W      = 6;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int MS_W       = 16;
	localparam int TAPS_W     = 8;
	localparam int AVG_W      = 16;

	// The beat fraction is a full signed word: a tempo written while running
	// changes the subtrahend but not the remainder, so the fraction can drift.
	localparam int ACC_W      = 32;

	// Divider operand widths: the tap numerator reaches 60000 * 254.
	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = 16;

	// Tempo constants.
	localparam logic [BPM_W-1:0] DEFAULT_BPM = 8'd120;
	localparam logic [BPM_W-1:0] BPM_MIN     = 8'd30;
	localparam logic [BAR_W-1:0] DEFAULT_BAR = 4'd4;
	localparam logic [MS_W-1:0]  MS_PER_MIN  = 16'd60000;
	localparam logic [9:0]       MS_PER_SEC  = 10'd1000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_start;
		logic commit;
	} ttm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} ttm_status_t;

endpackage

`default_nettype wire

@@ rtl/tap_tempo_metronome.sv @@
`default_nettype none

// Tap-tempo metronome driven by one word per tick, start/stop, tap-mode entry or tap.
// Each word yields exactly one result word. A word that needs no division goes from
// the execute state straight to the done state, where its result is registered.
// A start, and a tap in tap mode that is timed against an earlier tap over a nonzero
// interval, run the shared radix-2 restoring divider, 24 steps of one quotient bit
// each, in the divide state before the done state, whether or not the averaged
// tempo is accepted. A result that still waits on out_ready holds back the commit
// of the following word for as long as the stall lasts.
// The next word is taken as soon as the previous result is registered, even while
// that result still waits on out_ready. Configuration registers may be written
// only while no word is in flight; a write to preset_bpm takes effect at once.
module tap_tempo_metronome
	import ttm_pkg::*;
#(
	parameter int TICK_RATE          = 64,
	parameter int TAP_WINDOW_SECONDS = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            op,
	input  wire logic [SEC_W-1:0]      tap_second,
	input  wire logic [SUB_W-1:0]      tap_subsecond,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       beat_pulse,
	output logic                       accent,
	output logic                       sound_pulse,
	output logic                       blank_display,
	output logic                       tempo_updated,
	output logic [MODE_W-1:0]          run_mode,
	output logic [BPM_W-1:0]           tempo,
	output logic                       tap_timeout_active,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ttm_cmd_t    cmd;
	ttm_status_t status;

	// Sequencer and handshakes.
	ttm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Metronome state, tap timing and divider.
	ttm_dp #(
		.TICK_RATE          (TICK_RATE),
		.TAP_WINDOW_SECONDS (TAP_WINDOW_SECONDS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.op                 (op),
		.tap_second         (tap_second),
		.tap_subsecond      (tap_subsecond),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.beat_pulse         (beat_pulse),
		.accent             (accent),
		.sound_pulse        (sound_pulse),
		.blank_display      (blank_display),
		.tempo_updated      (tempo_updated),
		.run_mode           (run_mode),
		.tempo              (tempo),
		.tap_timeout_active (tap_timeout_active)
	);

endmodule

`default_nettype wire

@@ rtl/ttm_div.sv @@
`default_nettype none

module ttm_div
	import ttm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient,
	output logic [DIVISOR_W-1:0]       remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;

	logic [DIVISOR_W:0]    partial;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// One restoring step: bring down the next dividend bit and try the divisor.
	always_comb begin
		partial = {rem_q, quo_q[DIVIDEND_W-1]};
		trial   = partial - {1'b0, dsr_q};
		fits    = !trial[DIVISOR_W];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial-remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ rtl/ttm_dp.sv @@
`default_nettype none

module ttm_dp
	import ttm_pkg::*;
#(
	parameter int TICK_RATE          = 64,
	parameter int TAP_WINDOW_SECONDS = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ttm_cmd_t              cmd,
	output ttm_status_t                status,
	input  wire logic [1:0]            op,
	input  wire logic [SEC_W-1:0]      tap_second,
	input  wire logic [SUB_W-1:0]      tap_subsecond,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       beat_pulse,
	output logic                       accent,
	output logic                       sound_pulse,
	output logic                       blank_display,
	output logic                       tempo_updated,
	output logic [MODE_W-1:0]          run_mode,
	output logic [BPM_W-1:0]           tempo,
	output logic                       tap_timeout_active
);

	localparam int TOTAL_TICKS = 60 * TICK_RATE;
	localparam int CNT_W       = $clog2(TOTAL_TICKS + 2);
	localparam int HALF_W      = CNT_W - 1;
	localparam int WIN_LOAD    = TAP_WINDOW_SECONDS * TICK_RATE;
	localparam int WIN_W       = $clog2(WIN_LOAD + 1);
	localparam int SUB_MS_MAX  = ((2 ** SUB_W - 1) * 1000) / TICK_RATE;
	localparam int SUB_MS_W    = $clog2(SUB_MS_MAX + 1);
	localparam int RAW_MS_MAX  = (2 ** SEC_W - 1) * 1000 + SUB_MS_MAX;
	localparam int RAW_MS_W    = $clog2(RAW_MS_MAX + 1);

	// Captured input word.
	op_t              op_q;
	logic [SEC_W-1:0] sec_q;
	logic [SUB_W-1:0] sub_q;

	// Configuration and metronome state.
	logic [BAR_W-1:0]  bpb_q;
	logic              snd_q;
	logic [BPM_W-1:0]  bpm_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  period_q;
	logic [BPM_W-1:0]  prem_q;
	logic [CNT_W-1:0]  tick_q;
	logic [HALF_W-1:0] half_q;
	logic [ACC_W-1:0]  acc_q;
	logic [BAR_W-1:0]  idx_q;
	logic [MS_W-1:0]   first_q;
	logic [TAPS_W-1:0] taps_q;
	logic [WIN_W-1:0]  win_q;

	// Result register.
	logic              res_beat_q;
	logic              res_accent_q;
	logic              res_sound_q;
	logic              res_blank_q;
	logic              res_updated_q;
	mode_t             res_mode_q;
	logic [BPM_W-1:0]  res_tempo_q;
	logic              res_win_q;

	// Next-state values.
	logic [BPM_W-1:0]  bpm_d;
	mode_t             mode_d;
	logic [CNT_W-1:0]  period_d;
	logic [BPM_W-1:0]  prem_d;
	logic [CNT_W-1:0]  tick_d;
	logic [HALF_W-1:0] half_d;
	logic [ACC_W-1:0]  acc_d;
	logic [BAR_W-1:0]  idx_d;
	logic [MS_W-1:0]   first_d;
	logic [TAPS_W-1:0] taps_d;
	logic [WIN_W-1:0]  win_d;
	logic              beat_d;
	logic              accent_d;
	logic              blank_d;
	logic              updated_d;

	// Divider connections.
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic [DIVIDEND_W-1:0] div_quotient;
	logic [DIVISOR_W-1:0]  div_remainder;
	logic                  div_done;

	// Tap timing.
	logic [SUB_MS_W-1:0] sub_ms_tab [2**SUB_W];
	logic [RAW_MS_W-1:0] raw_ms;
	logic [MS_W-1:0]     now_ms;
	logic [MS_W-1:0]     tap_first;
	logic [MS_W-1:0]     elapsed;
	logic [TAPS_W-1:0]   taps_next;
	logic                tap_live;
	logic                tap_div;
	logic [AVG_W-1:0]    avg;
	logic                avg_ok;

	// Run timing.
	logic signed [ACC_W-1:0] acc_x100;
	logic [14:0]         bpm_x99;
	logic                long_beat;
	logic [CNT_W-1:0]    target;
	logic [CNT_W-1:0]    tc1;
	logic [BPM_W-1:0]    bpm_eff;
	logic                start_go;

	// Capture the accepted input word.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(op);
			sec_q <= tap_second;
			sub_q <= tap_subsecond;
		end
	end

	// Milliseconds of each subsecond count, fixed at elaboration.
	for (genvar gi = 0; gi < 2 ** SUB_W; gi++) begin : g_sub_ms
		localparam int SubMs = (gi * 1000) / TICK_RATE;
		assign sub_ms_tab[gi] = SUB_MS_W'(SubMs);
	end

	// Tap time in milliseconds within the minute, and time since the first tap.
	always_comb begin
		raw_ms    = RAW_MS_W'(sec_q) * RAW_MS_W'(MS_PER_SEC) + RAW_MS_W'(sub_ms_tab[sub_q]);
		now_ms    = (raw_ms >= RAW_MS_W'(MS_PER_MIN)) ? MS_W'(raw_ms - RAW_MS_W'(MS_PER_MIN))
			: MS_W'(raw_ms);
		tap_first = (taps_q == '0) ? now_ms : first_q;
		elapsed   = (now_ms >= tap_first) ? now_ms - tap_first
			: (MS_PER_MIN - tap_first) + now_ms;
		taps_next = taps_q + TAPS_W'(1);
		tap_live  = (mode_q == MODE_TAP);
		tap_div   = (elapsed != '0) && (taps_next > TAPS_W'(1));
		avg       = div_quotient[AVG_W-1:0];
		avg_ok    = (avg[AVG_W-1:BPM_W] == '0) && (avg[BPM_W-1:0] >= BPM_MIN);
	end

	// Start decision and the tempo used for it.
	always_comb begin
		bpm_eff  = (bpm_q == '0) ? DEFAULT_BPM : bpm_q;
		start_go = (win_q != '0) || (mode_q != MODE_RUN);
	end

	// A beat runs one tick long once the fraction reaches 0.99 of a tick.
	always_comb begin
		acc_x100  = $signed(acc_q) * $signed(ACC_W'(100));
		bpm_x99   = 15'(16'(bpm_q) * 16'd99);
		long_beat = acc_x100 >= $signed(ACC_W'(bpm_x99));
		target    = period_q + CNT_W'(long_beat);
		tc1       = tick_q + CNT_W'(1);
	end

	// Divider operands: the tap average or the beat period.
	always_comb begin
		if (op_q == OP_TAP) begin
			div_dividend = DIVIDEND_W'(MS_PER_MIN * DIVIDEND_W'(taps_q));
			div_divisor  = elapsed;
		end else begin
			div_dividend = DIVIDEND_W'(TOTAL_TICKS);
			div_divisor  = DIVISOR_W'(bpm_eff);
		end
	end

	always_comb begin
		status.need_div = ((op_q == OP_START_STOP) && start_go)
			|| ((op_q == OP_TAP) && tap_live && tap_div);
		status.div_done = div_done;
	end

	ttm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	// Next state and result fields for the captured word.
	always_comb begin
		bpm_d     = bpm_q;
		mode_d    = mode_q;
		period_d  = period_q;
		prem_d    = prem_q;
		tick_d    = tick_q;
		half_d    = half_q;
		acc_d     = acc_q;
		idx_d     = idx_q;
		first_d   = first_q;
		taps_d    = taps_q;
		win_d     = win_q;
		beat_d    = 1'b0;
		accent_d  = 1'b0;
		blank_d   = 1'b0;
		updated_d = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				if (mode_q == MODE_RUN) begin
					if (tc1 >= target) begin
						beat_d   = 1'b1;
						accent_d = (idx_q == BAR_W'(1));
						tick_d   = '0;
						acc_d    = acc_q - (long_beat ? ACC_W'(bpm_q) : '0) + ACC_W'(prem_q);
						idx_d    = (idx_q < bpb_q) ? idx_q + BAR_W'(1) : BAR_W'(1);
					end else begin
						tick_d  = tc1;
						blank_d = (tc1 == {1'b0, half_q});
					end
				end else if (win_q != '0) begin
					win_d = win_q - WIN_W'(1);
					if (win_q == WIN_W'(1)) begin
						mode_d = MODE_WAIT;
					end
				end
			end
			OP_START_STOP: begin
				win_d = '0;
				if (start_go) begin
					bpm_d    = bpm_eff;
					mode_d   = MODE_RUN;
					period_d = div_quotient[CNT_W-1:0];
					prem_d   = div_remainder[BPM_W-1:0];
					tick_d   = '0;
					half_d   = div_quotient[CNT_W-1:1];
					acc_d    = '0;
					idx_d    = BAR_W'(1);
				end else begin
					mode_d = MODE_WAIT;
				end
			end
			OP_ENTER_TAP: begin
				if (mode_q == MODE_WAIT) begin
					mode_d  = MODE_TAP;
					taps_d  = '0;
					first_d = '0;
					win_d   = WIN_W'(WIN_LOAD);
				end
			end
			OP_TAP: begin
				if (tap_live) begin
					first_d = tap_first;
					taps_d  = taps_next;
					win_d   = WIN_W'(WIN_LOAD);
					if (tap_div && avg_ok) begin
						bpm_d     = avg[BPM_W-1:0];
						updated_d = 1'b1;
					end
				end
			end
		endcase
	end

	// State update on commit, register writes in cycles without a commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q    <= DEFAULT_BAR;
			snd_q    <= 1'b1;
			bpm_q    <= DEFAULT_BPM;
			mode_q   <= MODE_WAIT;
			period_q <= '0;
			prem_q   <= '0;
			tick_q   <= '0;
			half_q   <= '0;
			acc_q    <= '0;
			idx_q    <= BAR_W'(1);
			first_q  <= '0;
			taps_q   <= '0;
			win_q    <= '0;
		end else if (cmd.commit) begin
			bpm_q    <= bpm_d;
			mode_q   <= mode_d;
			period_q <= period_d;
			prem_q   <= prem_d;
			tick_q   <= tick_d;
			half_q   <= half_d;
			acc_q    <= acc_d;
			idx_q    <= idx_d;
			first_q  <= first_d;
			taps_q   <= taps_d;
			win_q    <= win_d;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BEATS_PER_BAR: bpb_q <= cfg_data[BAR_W-1:0];
				REG_SOUND_ENABLE:  snd_q <= cfg_data[0];
				REG_PRESET_BPM:    bpm_q <= cfg_data[BPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Result register, loaded together with the state.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_beat_q    <= beat_d;
			res_accent_q  <= accent_d;
			res_sound_q   <= beat_d & snd_q;
			res_blank_q   <= blank_d;
			res_updated_q <= updated_d;
			res_mode_q    <= mode_d;
			res_tempo_q   <= bpm_d;
			res_win_q     <= (win_d != '0);
		end
	end

	assign beat_pulse         = res_beat_q;
	assign accent             = res_accent_q;
	assign sound_pulse        = res_sound_q;
	assign blank_display      = res_blank_q;
	assign tempo_updated      = res_updated_q;
	assign run_mode           = res_mode_q;
	assign tempo              = res_tempo_q;
	assign tap_timeout_active = res_win_q;

endmodule

`default_nettype wire

@@ rtl/ttm_ctrl.sv @@
`default_nettype none

`include "tap_tempo_metronome_defines.svh"

module ttm_ctrl
	import ttm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire ttm_status_t status,
	output ttm_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	// Commands to the datapath.
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.capture   = in_valid && in_ready;
		cmd.div_start = (state_q == ST_EXEC) && status.need_div;
		cmd.commit    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// Sequencing of one word: capture, optional divide, commit.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.capture) state_d = ST_EXEC;
			ST_EXEC: state_d = status.need_div ? ST_DIV : ST_DONE;
			ST_DIV:  if (status.div_done) state_d = ST_DONE;
			ST_DONE: if (cmd.commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`TTM_ASSERT_NXT(a_capture_to_exec, cmd.capture, state_q == ST_EXEC, "capture did not start work")
	`TTM_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_ready, !cmd.commit, "result overwritten")
	`TTM_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_q, "committed result not presented")
	`TTM_ASSERT_IMP(a_done_in_div, status.div_done, state_q == ST_DIV, "divider done outside wait")

endmodule

`default_nettype wire
